@@ rtl/nggp_pkg.sv @@
// ----------------------------------------------------------------------------
// nggp_pkg: shared types for the GGA sentence parser
// Parse phase, configuration bundle and the raw fix record handed from the
// byte parser to the coordinate conversion pipeline.
// ----------------------------------------------------------------------------
package nggp_pkg;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ID   = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	localparam int TIME_W    = 7;
	localparam int LAT_DEG_W = 7;
	localparam int LON_DEG_W = 10;
	// Minutes held in millionths of a minute after a field closes (below 10^8).
	localparam int UMIN_W    = 27;
	localparam int LAT_W     = 27;
	localparam int LON_W     = 30;

	typedef struct packed {
		logic [7:0]  sync_char;
		logic [7:0]  delim_char;
		logic [7:0]  check_char;
		logic [39:0] sentence_id;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0]    hour;
		logic [TIME_W-1:0]    minute;
		logic [TIME_W-1:0]    second;
		logic [LAT_DEG_W-1:0] lat_deg;
		logic [UMIN_W-1:0]    lat_umin;
		logic [LON_DEG_W-1:0] lon_deg;
		logic [UMIN_W-1:0]    lon_umin;
		logic                 south;
		logic                 west;
		logic                 fix_valid;
	} fix_raw_t;

endpackage

@@ rtl/nmea_gga_sentence_parser_unit.sv @@
// ----------------------------------------------------------------------------
// nmea_gga_sentence_parser_unit: GGA position sentence parser
// Parses a byte stream of GGA sentences and emits time, coordinates in
// micro-degrees, hemisphere flags and the fix flag for every good sentence.
// ----------------------------------------------------------------------------
// One received byte is taken on every clock while the conversion pipeline can
// accept: the per-byte state update (sync and ID compare, checksum XOR,
// decimal multiply-add and the rescaling multiply when a coordinate field
// closes) is combinational. Results pass through a three-register conversion
// pipeline whose stages stall one by one, so bytes keep flowing while a result
// waits on the output. Configuration sits at byte addresses 0 (sync), 8
// (delimiter), 16 (check) and 24 (sentence ID, first character in the top used
// byte); the user must write it only while idle; the block does not check.
module nmea_gga_sentence_parser_unit #(
	parameter int FRAC_DIGITS = 4,
	parameter int ID_LEN      = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [6:0] hour, [13:7] minute, [20:14] second, [47:21] latitude_udeg,
	// [77:48] longitude_udeg, [79:78] zero
	output logic [79:0] m_tdata,
	output logic [2:0]  m_tuser    // [0] south, [1] west, [2] fix_valid
);
	import nggp_pkg::*;

	localparam logic [1:0]  REG_SYNC  = 2'd0;
	localparam logic [1:0]  REG_DELIM = 2'd1;
	localparam logic [1:0]  REG_CHECK = 2'd2;
	localparam logic [1:0]  REG_ID    = 2'd3;
	localparam logic [7:0]  SYNC_RST  = 8'h24;
	localparam logic [7:0]  DELIM_RST = 8'h2C;
	localparam logic [7:0]  CHECK_RST = 8'h2A;
	localparam logic [39:0] ID_RST    = 40'd306255972161;

	cfg_t       cfg_q;
	logic       cfg_we;
	logic [1:0] reg_idx;
	logic       in_accept;
	logic       fix_push;
	fix_raw_t   fix;
	logic       conv_ready;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_char   <= SYNC_RST;
			cfg_q.delim_char  <= DELIM_RST;
			cfg_q.check_char  <= CHECK_RST;
			cfg_q.sentence_id <= ID_RST;
		end else if (cfg_we) begin
			unique case (reg_idx)
				REG_SYNC:  cfg_q.sync_char   <= pwdata[7:0];
				REG_DELIM: cfg_q.delim_char  <= pwdata[7:0];
				REG_CHECK: cfg_q.check_char  <= pwdata[7:0];
				REG_ID:    cfg_q.sentence_id <= pwdata[39:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SYNC:  prdata = {56'd0, cfg_q.sync_char};
			REG_DELIM: prdata = {56'd0, cfg_q.delim_char};
			REG_CHECK: prdata = {56'd0, cfg_q.check_char};
			REG_ID:    prdata = {24'd0, cfg_q.sentence_id};
			default:   prdata = 64'd0;
		endcase
	end

	assign s_tready  = conv_ready;
	assign in_accept = s_tvalid && s_tready;

	nggp_parser #(
		.FRAC_DIGITS(FRAC_DIGITS),
		.ID_LEN     (ID_LEN)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_accept(in_accept),
		.rx_byte  (s_tdata),
		.cfg      (cfg_q),
		.fix_push (fix_push),
		.fix      (fix)
	);

	nggp_convert u_convert (
		.clk     (clk),
		.arst_n  (arst_n),
		.fix_push(fix_push),
		.fix     (fix),
		.in_ready(conv_ready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

@@ rtl/nggp_parser.sv @@
// ----------------------------------------------------------------------------
// nggp_parser: byte-level sentence parser
// Updates the sentence state for every accepted byte and presents a raw fix
// record when a sentence with a good checksum ends.
// ----------------------------------------------------------------------------
module nggp_parser #(
	parameter int FRAC_DIGITS = 4,
	parameter int ID_LEN      = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_accept,
	input  logic [7:0]        rx_byte,
	input  nggp_pkg::cfg_t    cfg,
	output logic              fix_push,
	output nggp_pkg::fix_raw_t fix
);
	import nggp_pkg::*;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_POINT   = 8'h2E;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_S       = 8'h53;
	localparam logic [7:0] CH_W       = 8'h57;
	localparam logic [3:0] ID_LEN_C   = 4'(ID_LEN);
	localparam logic [2:0] FRAC_C     = 3'(FRAC_DIGITS);
	localparam logic [2:0] ID_LAST    = 3'(ID_LEN - 1);
	localparam logic [1:0] HEX_STOP   = 2'd3;

	typedef struct packed {
		phase_t               phase;
		logic [3:0]           id_pos;
		logic                 id_mismatch;
		logic [7:0]           xor_acc;
		logic [2:0]           field_num;
		logic [3:0]           char_idx;
		logic                 check_seen;
		logic [7:0]           rx_check;
		logic [1:0]           hex_cnt;
		logic [2:0][TIME_W-1:0] time_acc;
		logic [LAT_DEG_W-1:0] lat_deg;
		logic [UMIN_W-1:0]    lat_umin;
		logic [LON_DEG_W-1:0] lon_deg;
		logic [UMIN_W-1:0]    lon_umin;
		logic [2:0]           frac_cnt;
		logic                 seen_dp;
		logic [2:0]           flags;
	} pstate_t;

	pstate_t st_q, st_d;

	function automatic logic [3:0] dec_digit(input logic [7:0] c);
		logic [7:0] d;
		d = c - CH_ZERO;
		return (c >= CH_ZERO && c <= 8'h39) ? d[3:0] : 4'd0;
	endfunction

	function automatic logic [19:0] pow10(input logic [2:0] e);
		logic [19:0] r;
		case (e)
			3'd0:    r = 20'd1;
			3'd1:    r = 20'd10;
			3'd2:    r = 20'd100;
			3'd3:    r = 20'd1000;
			3'd4:    r = 20'd10000;
			3'd5:    r = 20'd100000;
			3'd6:    r = 20'd1000000;
			default: r = 20'd1;
		endcase
		return r;
	endfunction

	logic [7:0]        c;
	logic [3:0]        dig;
	logic              hex_ok;
	logic [3:0]        hex_v;
	logic [63:0]       id_ext;
	logic [2:0]        id_sel;
	logic [7:0]        id_byte;
	logic              is_lon;
	logic [3:0]        deg_len;
	logic [UMIN_W-1:0] mins_cur;
	logic [UMIN_W-1:0] mins_next;
	logic [46:0]       scale_prod;
	logic [UMIN_W-1:0] mins_scaled;
	logic [1:0]        slot;

	assign c   = rx_byte;
	assign dig = dec_digit(c);

	always_comb begin
		hex_ok = 1'b1;
		hex_v  = 4'd0;
		if (c >= CH_ZERO && c <= 8'h39) begin
			hex_v = 4'(c - CH_ZERO);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			hex_v = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			hex_v = 4'(c - 8'h57);
		end else begin
			hex_ok = 1'b0;
		end
	end

	// Bytes of the ID beyond the 40-bit register compare against zero.
	assign id_ext  = {24'd0, cfg.sentence_id};
	assign id_sel  = ID_LAST - st_q.id_pos[2:0];
	assign id_byte = id_ext[{id_sel, 3'b000} +: 8];

	assign is_lon     = (st_q.field_num == 3'd3);
	assign deg_len    = is_lon ? 4'd3 : 4'd2;
	assign mins_cur   = is_lon ? st_q.lon_umin : st_q.lat_umin;
	assign mins_next  = UMIN_W'(mins_cur * UMIN_W'(10) + UMIN_W'(dig));
	// Closing a coordinate field rescales the minutes to millionths of a minute.
	assign scale_prod  = 47'(mins_cur) * 47'(pow10(3'd6 - st_q.frac_cnt));
	assign mins_scaled = scale_prod[UMIN_W-1:0];
	assign slot        = st_q.char_idx[2:1];

	always_comb begin
		st_d     = st_q;
		fix_push = 1'b0;
		if (in_accept) begin
			if (c == cfg.sync_char) begin
				st_d       = '0;
				st_d.phase = PH_ID;
			end else begin
				unique case (st_q.phase)
					PH_ID: begin
						st_d.xor_acc = st_q.xor_acc ^ c;
						if (c == cfg.delim_char) begin
							st_d.phase = (!st_q.id_mismatch && st_q.id_pos == ID_LEN_C)
								? PH_BODY : PH_IDLE;
						end else begin
							if (st_q.id_pos >= ID_LEN_C || id_byte != c)
								st_d.id_mismatch = 1'b1;
							if (st_q.id_pos != 4'hF)
								st_d.id_pos = st_q.id_pos + 4'd1;
						end
					end
					PH_BODY: begin
						if (c == CH_NEWLINE) begin
							st_d.phase = PH_IDLE;
							fix_push   = st_q.check_seen && (st_q.rx_check == st_q.xor_acc);
						end else if (st_q.check_seen) begin
							if (st_q.hex_cnt != HEX_STOP && hex_ok) begin
								st_d.rx_check = {st_q.rx_check[3:0], hex_v};
								if (st_q.hex_cnt < 2'd2)
									st_d.hex_cnt = st_q.hex_cnt + 2'd1;
							end else begin
								st_d.hex_cnt = HEX_STOP;
							end
						end else if (c == cfg.check_char || c == CH_COMMA) begin
							if (st_q.field_num == 3'd1)
								st_d.lat_umin = mins_scaled;
							if (st_q.field_num == 3'd3)
								st_d.lon_umin = mins_scaled;
							st_d.frac_cnt = 3'd0;
							st_d.seen_dp  = 1'b0;
							if (c == cfg.check_char) begin
								st_d.check_seen = 1'b1;
							end else begin
								st_d.xor_acc  = st_q.xor_acc ^ c;
								st_d.char_idx = 4'd0;
								if (st_q.field_num != 3'd7)
									st_d.field_num = st_q.field_num + 3'd1;
							end
						end else begin
							st_d.xor_acc = st_q.xor_acc ^ c;
							case (st_q.field_num)
								3'd0: begin
									if (st_q.char_idx < 4'd6) begin
										if (st_q.char_idx[0])
											st_d.time_acc[slot] = st_q.time_acc[slot]
												+ TIME_W'(dig);
										else
											st_d.time_acc[slot] = TIME_W'(dig * 4'd10);
									end
								end
								3'd1, 3'd3: begin
									if (st_q.seen_dp) begin
										if (st_q.frac_cnt < FRAC_C) begin
											if (is_lon) st_d.lon_umin = mins_next;
											else        st_d.lat_umin = mins_next;
											st_d.frac_cnt = st_q.frac_cnt + 3'd1;
										end
									end else if (st_q.char_idx < deg_len) begin
										if (is_lon)
											st_d.lon_deg = LON_DEG_W'(st_q.lon_deg
												* LON_DEG_W'(10) + LON_DEG_W'(dig));
										else
											st_d.lat_deg = LAT_DEG_W'(st_q.lat_deg
												* LAT_DEG_W'(10) + LAT_DEG_W'(dig));
									end else if (c == CH_POINT) begin
										st_d.seen_dp = 1'b1;
									end else if (st_q.char_idx < deg_len + 4'd2) begin
										if (is_lon) st_d.lon_umin = mins_next;
										else        st_d.lat_umin = mins_next;
									end
								end
								3'd2: if (st_q.char_idx == 4'd0 && c == CH_S) st_d.flags[0] = 1'b1;
								3'd4: if (st_q.char_idx == 4'd0 && c == CH_W) st_d.flags[1] = 1'b1;
								3'd5: if (st_q.char_idx == 4'd0 && c == CH_ZERO) st_d.flags[2] = 1'b1;
								default: ;
							endcase
							if (st_q.char_idx != 4'hF)
								st_d.char_idx = st_q.char_idx + 4'd1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= '0;
			st_q.phase <= PH_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		fix.hour      = st_q.time_acc[0];
		fix.minute    = st_q.time_acc[1];
		fix.second    = st_q.time_acc[2];
		fix.lat_deg   = st_q.lat_deg;
		fix.lat_umin  = st_q.lat_umin;
		fix.lon_deg   = st_q.lon_deg;
		fix.lon_umin  = st_q.lon_umin;
		fix.south     = st_q.flags[0];
		fix.west      = st_q.flags[1];
		fix.fix_valid = ~st_q.flags[2];
	end

	a_body_id_ok: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_BODY |-> st_q.id_pos == ID_LEN_C && !st_q.id_mismatch)
		else $error("body phase entered without a matching sentence ID");

	a_hex_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.check_seen |-> st_q.hex_cnt == 2'd0 && st_q.rx_check == 8'd0)
		else $error("checksum digits collected before the check character");

	a_frac_limit: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.frac_cnt <= FRAC_C)
		else $error("fraction digit count beyond its limit");

endmodule

@@ rtl/nggp_convert.sv @@
// ----------------------------------------------------------------------------
// nggp_convert: coordinate conversion pipeline
// Three elastic register stages turn degrees and millionths of a minute into
// micro-degrees and hold the result for the output stream.
// ----------------------------------------------------------------------------
module nggp_convert (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fix_push,
	input  nggp_pkg::fix_raw_t fix,
	output logic               in_ready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [79:0]        m_tdata,
	output logic [2:0]         m_tuser
);
	import nggp_pkg::*;

	// floor(x / 60) as (x * RECIP60) >> RECIP_SHIFT, exact for x below 2^27.
	localparam logic [27:0] RECIP60     = 28'd143165577;
	localparam int          RECIP_SHIFT = 33;
	localparam int          FRAC_W      = 21;
	localparam logic [19:0] MEGA        = 20'd1000000;

	fix_raw_t f_s1;
	logic     v_s1;

	logic [TIME_W-1:0] hour_s2, minute_s2, second_s2;
	logic              south_s2, west_s2, fixv_s2;
	logic [LAT_W-1:0]  lat_deg_s2;
	logic [LON_W-1:0]  lon_deg_s2;
	logic [FRAC_W-1:0] lat_frac_s2, lon_frac_s2;
	logic              v_s2;

	logic [TIME_W-1:0] hour_q, minute_q, second_q;
	logic              south_q, west_q, fixv_q;
	logic [LAT_W-1:0]  lat_q;
	logic [LON_W-1:0]  lon_q;
	logic              valid_q;

	logic rdy_out, rdy_s2;
	logic [54:0] lat_prod, lon_prod;

	assign rdy_out  = !valid_q || m_tready;
	assign rdy_s2   = !v_s2 || rdy_out;
	assign in_ready = !v_s1 || rdy_s2;

	assign lat_prod = 55'(f_s1.lat_umin) * 55'(RECIP60);
	assign lon_prod = 55'(f_s1.lon_umin) * 55'(RECIP60);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= fix_push;
			if (rdy_s2)   v_s2 <= v_s1;
			if (rdy_out)  valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fix_push && in_ready)
			f_s1 <= fix;
		if (v_s1 && rdy_s2) begin
			hour_s2     <= f_s1.hour;
			minute_s2   <= f_s1.minute;
			second_s2   <= f_s1.second;
			south_s2    <= f_s1.south;
			west_s2     <= f_s1.west;
			fixv_s2     <= f_s1.fix_valid;
			lat_deg_s2  <= LAT_W'(LAT_W'(f_s1.lat_deg) * LAT_W'(MEGA));
			lon_deg_s2  <= LON_W'(LON_W'(f_s1.lon_deg) * LON_W'(MEGA));
			lat_frac_s2 <= lat_prod[RECIP_SHIFT +: FRAC_W];
			lon_frac_s2 <= lon_prod[RECIP_SHIFT +: FRAC_W];
		end
		if (v_s2 && rdy_out) begin
			hour_q   <= hour_s2;
			minute_q <= minute_s2;
			second_q <= second_s2;
			south_q  <= south_s2;
			west_q   <= west_s2;
			fixv_q   <= fixv_s2;
			lat_q    <= lat_deg_s2 + LAT_W'(lat_frac_s2);
			lon_q    <= lon_deg_s2 + LON_W'(lon_frac_s2);
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, lon_q, lat_q, second_q, minute_q, hour_q};
	assign m_tuser  = {fixv_q, west_q, south_q};

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> lat_q <= LAT_W'(100666665) && lon_q <= LON_W'(1000666665))
		else $error("converted coordinate out of range");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !rdy_s2 |=> v_s1 && $stable(f_s1))
		else $error("first stage changed while stalled");

	a_s2_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && rdy_out |=> valid_q)
		else $error("second stage result lost on its way to the output");

endmodule

@@ tb/nmea_gga_sentence_parser_unit_test.sv @@
// ----------------------------------------------------------------------------
// nmea_gga_sentence_parser_unit_test: self-checking bench for the GGA parser
// Streams whole sentences, broken sentences and line noise into the parser
// under several register settings. A bit-true predictor works out the fix
// that each accepted byte produces, and every output transaction is checked
// field by field against the oldest pending fix.
// ----------------------------------------------------------------------------
module nmea_gga_sentence_parser_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import nggp_pkg::*;

	localparam int FRAC_DIGITS = 4;
	localparam int ID_LEN      = 5;
	localparam int PIPE_SETTLE = 8;
	localparam int TIMEOUT_NS  = 2_000_000;

	localparam bit [4:0] REG_SYNC  = 5'd0;
	localparam bit [4:0] REG_DELIM = 5'd8;
	localparam bit [4:0] REG_CHECK = 5'd16;
	localparam bit [4:0] REG_ID    = 5'd24;

	localparam bit [7:0] CH_NL    = 8'h0A;
	localparam bit [7:0] CH_CR    = 8'h0D;
	localparam bit [7:0] CH_COMMA = 8'h2C;
	localparam bit [7:0] CH_DOT   = 8'h2E;
	localparam bit [7:0] CH_ZERO  = 8'h30;
	localparam bit [7:0] CH_NINE  = 8'h39;
	localparam bit [7:0] CH_UA    = 8'h41;
	localparam bit [7:0] CH_UF    = 8'h46;
	localparam bit [7:0] CH_UZ    = 8'h5A;
	localparam bit [7:0] CH_S     = 8'h53;
	localparam bit [7:0] CH_W     = 8'h57;
	localparam bit [7:0] CH_LA    = 8'h61;
	localparam bit [7:0] CH_LF    = 8'h66;
	localparam bit [7:0] CH_LG    = 8'h67;
	localparam bit [7:0] CH_SPACE = 8'h20;

	localparam string CANONICAL = "123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,";

	typedef enum int {
		SENT_GOOD,
		SENT_LOWER_HEX,
		SENT_EXTRA_HEX,
		SENT_TRAIL,
		SENT_BAD_SUM,
		SENT_NO_CHECK,
		SENT_NO_DIGITS,
		SENT_BAD_ID,
		SENT_LONG_ID,
		SENT_SHORT_ID,
		SENT_CUT
	} sentence_kind_t;

	typedef struct {
		bit [6:0]  hour;
		bit [6:0]  minute;
		bit [6:0]  second;
		bit [26:0] lat;
		bit        south;
		bit [29:0] lon;
		bit        west;
		bit        fix;
	} fix_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [63:0] pwdata   = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [6:0] hour, [13:7] minute, [20:14] second, [47:21] latitude_udeg,
	// [77:48] longitude_udeg, [79:78] zero
	logic [79:0] m_tdata;
	logic [2:0]  m_tuser;         // [0] south, [1] west, [2] fix_valid

	nmea_gga_sentence_parser_unit #(
		.FRAC_DIGITS(FRAC_DIGITS),
		.ID_LEN(ID_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state, mirroring the parser one accepted byte at a time.
	cfg_t       cfg_now;
	phase_t     parse_st;
	bit [3:0]   id_pos;
	bit         id_bad;
	bit [7:0]   sum_acc;
	bit [2:0]   fld;
	bit [3:0]   fpos;
	bit         star_seen;
	bit [7:0]   rx_sum;
	bit [1:0]   hex_n;
	bit [6:0]   tacc[3];
	bit [31:0]  lat_d, lat_m, lon_d, lon_m;
	bit [2:0]   frac_n;
	bit         dot_seen;
	bit         s_flag, w_flag, zero_fix;

	fix_t pending_fixes[$];
	int   error_count     = 0;
	int   bytes_sent      = 0;
	int   fixes_predicted = 0;
	int   fixes_seen      = 0;
	int   burst_left      = 0;
	int   ready_left      = 0;
	int   ready_mode      = 0;

	task automatic flag_error(string msg);
		error_count++;
		$display("ERROR @%0t ns: %s", $time, msg);
	endtask

	function automatic bit [3:0] digit_of(bit [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) ? 4'(c - CH_ZERO) : 4'd0;
	endfunction

	function automatic bit hex_value(input bit [7:0] c, output bit [3:0] v);
		v = 4'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = 4'(c - CH_ZERO);
			return 1'b1;
		end
		if (c >= CH_UA && c <= CH_UF) begin
			v = 4'(c - CH_UA + 8'd10);
			return 1'b1;
		end
		if (c >= CH_LA && c <= CH_LF) begin
			v = 4'(c - CH_LA + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit [7:0] hex_char(bit [3:0] n, bit lower);
		if (n < 10)
			return CH_ZERO + 8'(n);
		return (lower ? CH_LA : CH_UA) + 8'(n) - 8'd10;
	endfunction

	function automatic bit [31:0] ten_pow(int k);
		bit [31:0] p = 1;
		repeat (k) p = p * 10;
		return p;
	endfunction

	function automatic bit [63:0] to_micro(bit [31:0] deg, bit [31:0] mins);
		bit [63:0] denom;
		denom = 64'd60 * ten_pow(FRAC_DIGITS);
		return 64'(deg) * 64'd1000000 + (64'(mins) * 64'd1000000) / denom;
	endfunction

	function automatic void clear_sentence_state();
		id_pos = 0; id_bad = 0; sum_acc = 0; fld = 0; fpos = 0;
		star_seen = 0; rx_sum = 0; hex_n = 0;
		tacc[0] = 0; tacc[1] = 0; tacc[2] = 0;
		lat_d = 0; lat_m = 0; lon_d = 0; lon_m = 0;
		frac_n = 0; dot_seen = 0; s_flag = 0; w_flag = 0; zero_fix = 0;
	endfunction

	// Minutes are rescaled to a fixed number of fraction digits when a
	// coordinate field closes, whatever number of digits was received.
	function automatic void close_field();
		int k;
		k = (frac_n <= FRAC_DIGITS) ? FRAC_DIGITS - frac_n : 0;
		if (fld == 3'd1)
			lat_m = lat_m * ten_pow(k);
		else if (fld == 3'd3)
			lon_m = lon_m * ten_pow(k);
		frac_n = 0;
		dot_seen = 0;
	endfunction

	function automatic void coord_char(bit [7:0] c, int deg_len, inout bit [31:0] deg,
			inout bit [31:0] mins);
		if (dot_seen) begin
			if (frac_n < FRAC_DIGITS) begin
				mins = mins * 10 + digit_of(c);
				frac_n++;
			end
			return;
		end
		if (fpos < deg_len) begin
			deg = deg * 10 + digit_of(c);
			return;
		end
		if (c == CH_DOT) begin
			dot_seen = 1;
			return;
		end
		if (fpos < deg_len + 2)
			mins = mins * 10 + digit_of(c);
	endfunction

	function automatic void emit_fix();
		fix_t f;
		bit [63:0] wide;
		f.hour = tacc[0];
		f.minute = tacc[1];
		f.second = tacc[2];
		wide = to_micro(lat_d, lat_m);
		f.lat = wide[26:0];
		f.south = s_flag;
		wide = to_micro(lon_d, lon_m);
		f.lon = wide[29:0];
		f.west = w_flag;
		f.fix = !zero_fix;
		pending_fixes.push_back(f);
		fixes_predicted++;
	endfunction

	function automatic void parse_predict(bit [7:0] c);
		bit [3:0] v;
		int sh;
		if (c == cfg_now.sync_char) begin
			clear_sentence_state();
			parse_st = PH_ID;
			return;
		end
		if (parse_st == PH_ID) begin
			sum_acc ^= c;
			if (c == cfg_now.delim_char) begin
				parse_st = (!id_bad && id_pos == ID_LEN) ? PH_BODY : PH_IDLE;
				return;
			end
			if (id_pos >= ID_LEN) begin
				id_bad = 1;
			end else begin
				sh = 8 * (ID_LEN - 1 - int'(id_pos));
				if (cfg_now.sentence_id[sh +: 8] != c)
					id_bad = 1;
			end
			if (id_pos < 15)
				id_pos++;
			return;
		end
		if (parse_st != PH_BODY)
			return;
		if (c == CH_NL) begin
			parse_st = PH_IDLE;
			if (star_seen && rx_sum == sum_acc)
				emit_fix();
			return;
		end
		if (star_seen) begin
			if (hex_n != 2'd3 && hex_value(c, v)) begin
				rx_sum = {rx_sum[3:0], v};
				if (hex_n < 2)
					hex_n++;
			end else begin
				hex_n = 2'd3;
			end
			return;
		end
		if (c == cfg_now.check_char) begin
			close_field();
			star_seen = 1;
			return;
		end
		sum_acc ^= c;
		if (c == CH_COMMA) begin
			close_field();
			if (fld < 7)
				fld++;
			fpos = 0;
			return;
		end
		case (fld)
			3'd0: begin
				if (fpos < 6) begin
					if (fpos[0])
						tacc[fpos >> 1] = tacc[fpos >> 1] + digit_of(c);
					else
						tacc[fpos >> 1] = digit_of(c) * 10;
				end
			end
			3'd1: coord_char(c, 2, lat_d, lat_m);
			3'd2: if (fpos == 0 && c == CH_S) s_flag = 1;
			3'd3: coord_char(c, 3, lon_d, lon_m);
			3'd4: if (fpos == 0 && c == CH_W) w_flag = 1;
			3'd5: if (fpos == 0 && c == CH_ZERO) zero_fix = 1;
			default: ;
		endcase
		if (fpos < 15)
			fpos++;
	endfunction

	// Byte source: random bursts with random gaps, some stretches back to back.
	task automatic send_rx_byte(bit [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do
			@(posedge clk);
		while (!s_tready);
		bytes_sent++;
		parse_predict(b);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_fixes.size() != 0)
			@(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	// One register write followed by a read-back of the same address.
	task automatic write_reg(bit [4:0] addr, bit [63:0] value);
		bit [63:0] mask;
		bit [63:0] got;
		mask = (addr == REG_ID) ? 64'h0000_00FF_FFFF_FFFF : 64'hFF;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (addr)
			REG_SYNC:  cfg_now.sync_char = value[7:0];
			REG_DELIM: cfg_now.delim_char = value[7:0];
			REG_CHECK: cfg_now.check_char = value[7:0];
			REG_ID:    cfg_now.sentence_id = value[39:0];
			default: ;
		endcase
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got != (value & mask))
			flag_error($sformatf("register at %0d reads %0h, expected %0h", addr, got,
				value & mask));
	endtask

	task automatic set_config(bit [7:0] sy, bit [7:0] de, bit [7:0] ck, bit [39:0] id);
		wait_idle();
		write_reg(REG_SYNC, 64'(sy));
		write_reg(REG_DELIM, 64'(de));
		write_reg(REG_CHECK, 64'(ck));
		write_reg(REG_ID, 64'(id));
	endtask

	// Frames a body with sync, ID and checksum under the current registers,
	// then damages it as the kind asks.
	task automatic send_sentence(string body, sentence_kind_t kind);
		bit [7:0] line[$];
		bit [7:0] sum;
		bit [7:0] id_ch;
		bit [7:0] trail[4];
		bit       lower;
		int       bad_pos;
		int       cut;
		lower = (kind == SENT_LOWER_HEX) ? 1'b1 : 1'($urandom_range(0, 1));
		bad_pos = $urandom_range(0, ID_LEN - 1);
		line.push_back(cfg_now.sync_char);
		for (int i = 0; i < ID_LEN; i++) begin
			id_ch = cfg_now.sentence_id[8 * (ID_LEN - 1 - i) +: 8];
			if (kind == SENT_BAD_ID && i == bad_pos)
				id_ch ^= 8'($urandom_range(1, 255));
			if (!(kind == SENT_SHORT_ID && i == ID_LEN - 1))
				line.push_back(id_ch);
		end
		if (kind == SENT_LONG_ID)
			line.push_back(CH_UA);
		line.push_back(cfg_now.delim_char);
		foreach (body[i])
			line.push_back(body[i]);
		sum = 0;
		for (int i = 1; i < line.size(); i++)
			sum ^= line[i];
		if (kind == SENT_BAD_SUM)
			sum ^= 8'($urandom_range(1, 255));
		if (kind != SENT_NO_CHECK) begin
			line.push_back(cfg_now.check_char);
			if (kind == SENT_EXTRA_HEX)
				line.push_back(hex_char(4'($urandom_range(0, 15)), lower));
			if (kind != SENT_NO_DIGITS) begin
				line.push_back(hex_char(sum[7:4], lower));
				line.push_back(hex_char(sum[3:0], lower));
			end
			if (kind == SENT_TRAIL) begin
				trail = '{CH_CR, cfg_now.check_char, CH_LG, CH_SPACE};
				line.push_back(trail[$urandom_range(0, 3)]);
				line.push_back(hex_char(4'($urandom_range(0, 15)), lower));
			end
		end
		line.push_back(CH_NL);
		if (kind == SENT_CUT) begin
			cut = $urandom_range(1, line.size() - 2);
			line = line[0:cut];
		end
		foreach (line[i])
			send_rx_byte(line[i]);
	endtask

	function automatic string digits(int n);
		string s = "";
		repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
		return s;
	endfunction

	function automatic string junk(int n);
		string pool = "x.-:A /+=";
		string s = "";
		int k;
		repeat (n) begin
			k = $urandom_range(0, pool.len() - 1);
			s = {s, pool.substr(k, k)};
		end
		return s;
	endfunction

	function automatic string random_time();
		case ($urandom_range(0, 7))
			0: return "";
			1: return digits($urandom_range(1, 9));
			2: return {digits(2), junk(1), digits(3)};
			default: return {digits(6), ".", digits(2)};
		endcase
	endfunction

	function automatic string random_coord(int deg_len);
		case ($urandom_range(0, 9))
			0: return "";
			1: return {digits(deg_len), junk(1), digits(1), ".", junk(1), digits(2)};
			2: return {digits($urandom_range(0, deg_len + 1)), ".", digits($urandom_range(0, 6))};
			3: return digits(deg_len + 2);
			4: return {digits(deg_len + $urandom_range(3, 5)), ".", digits(3)};
			default: return {digits(deg_len + 2), ".", digits($urandom_range(0, 6))};
		endcase
	endfunction

	function automatic string random_body();
		string ns_opt[5]  = '{"N", "S", "", "s", "SX"};
		string ew_opt[4]  = '{"E", "W", "", "w"};
		string fix_opt[6] = '{"0", "1", "2", "", "0x", "x"};
		string tail[4]    = '{"", "", ",08,0.9,545.4,M,46.9,M,,", ",,,,,,,,"};
		string t, la, lo;
		t = random_time();
		la = random_coord(2);
		lo = random_coord(3);
		if ($urandom_range(0, 11) == 0)
			return {t, ",", la};
		return {t, ",", la, ",", ns_opt[$urandom_range(0, 4)], ",", lo, ",",
			ew_opt[$urandom_range(0, 3)], ",", fix_opt[$urandom_range(0, 5)],
			tail[$urandom_range(0, 3)]};
	endfunction

	function automatic sentence_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return SENT_GOOD;
		if (r < 52) return SENT_LOWER_HEX;
		if (r < 60) return SENT_EXTRA_HEX;
		if (r < 68) return SENT_TRAIL;
		if (r < 74) return SENT_BAD_SUM;
		if (r < 79) return SENT_NO_CHECK;
		if (r < 82) return SENT_NO_DIGITS;
		if (r < 87) return SENT_BAD_ID;
		if (r < 90) return SENT_LONG_ID;
		if (r < 93) return SENT_SHORT_ID;
		return SENT_CUT;
	endfunction

	function automatic bit [7:0] pick_special();
		string pool = "!#$%&*@^~|;?<>";
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(128, 255));
		return pool[$urandom_range(0, pool.len() - 1)];
	endfunction

	// Mostly framed sentences with random content, some line noise, and now
	// and then a full drain of the parser before carrying on.
	task automatic run_sentences(int min_bytes, int min_fixes);
		int b0, f0, n;
		b0 = bytes_sent;
		f0 = fixes_predicted;
		n = 0;
		while (bytes_sent - b0 < min_bytes || fixes_predicted - f0 < min_fixes) begin
			n++;
			if (n % 16 == 0)
				wait_idle();
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 6)) send_rx_byte(8'($urandom_range(0, 255)));
			send_sentence(random_body(), pick_kind());
		end
	endtask

	task automatic test_directed();
		string idle_text = "xyz,1*00\n";
		foreach (idle_text[i])
			send_rx_byte(idle_text[i]);
		send_sentence(CANONICAL, SENT_GOOD);
		send_sentence("999999.99,9999.999999,S,99999.999999,W,0", SENT_LOWER_HEX);
		send_sentence("000000,0000.0000,N,00000.0000,E,1", SENT_EXTRA_HEX);
		send_sentence(",,,,,", SENT_TRAIL);
		send_sentence("", SENT_GOOD);
		send_sentence("1x3456,4a07.x38,s,011b1,w,x", SENT_GOOD);
		send_sentence("12,4.5,S,1.25,W,2", SENT_GOOD);
		send_sentence("0730,4807,N,01131,E,6,1,2,3,4,5,6,7,8", SENT_GOOD);
		send_sentence("12345678901234567890,480712345.1234567,N,0113199.9,E,00", SENT_GOOD);
		send_sentence(CANONICAL, SENT_BAD_SUM);
		send_sentence(CANONICAL, SENT_NO_CHECK);
		send_sentence(CANONICAL, SENT_NO_DIGITS);
		send_sentence(CANONICAL, SENT_BAD_ID);
		send_sentence(CANONICAL, SENT_LONG_ID);
		send_sentence(CANONICAL, SENT_SHORT_ID);
		send_sentence(CANONICAL, SENT_CUT);
		send_sentence(CANONICAL, SENT_GOOD);
		wait_idle();
	endtask

	task automatic test_register_extremes();
		set_config(8'h00, 8'h01, 8'hFE, 40'hFF_FFFF_FFFF);
		run_sentences(150, 4);
		set_config(8'hFF, 8'hFE, 8'h80, 40'h00_0000_0000);
		run_sentences(150, 4);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		bit [7:0]  sy, de, ck;
		bit [39:0] id;
		repeat (2) begin
			sy = pick_special();
			do de = pick_special(); while (de == sy);
			do ck = pick_special(); while (ck == sy || ck == de);
			for (int i = 0; i < 5; i++)
				id[8 * i +: 8] = 8'($urandom_range(CH_UA, CH_UZ));
			set_config(sy, de, ck, id);
			run_sentences(250, 12);
		end
		set_config(8'd36, 8'd44, 8'd42, 40'd306255972161);
		run_sentences(300, 12);
		wait_idle();
	endtask

	task automatic compare_fix(fix_t got, fix_t want);
		if (got.hour != want.hour)
			flag_error($sformatf("hour %0d, expected %0d", got.hour, want.hour));
		if (got.minute != want.minute)
			flag_error($sformatf("minute %0d, expected %0d", got.minute, want.minute));
		if (got.second != want.second)
			flag_error($sformatf("second %0d, expected %0d", got.second, want.second));
		if (got.lat != want.lat)
			flag_error($sformatf("latitude %0d, expected %0d", got.lat, want.lat));
		if (got.south != want.south)
			flag_error($sformatf("south %0d, expected %0d", got.south, want.south));
		if (got.lon != want.lon)
			flag_error($sformatf("longitude %0d, expected %0d", got.lon, want.lon));
		if (got.west != want.west)
			flag_error($sformatf("west %0d, expected %0d", got.west, want.west));
		if (got.fix != want.fix)
			flag_error($sformatf("fix_valid %0d, expected %0d", got.fix, want.fix));
	endtask

	// Result sink: checks every output transaction, then picks the next
	// ready value from one of three stall patterns, chosen at random.
	always @(posedge clk) begin : fix_monitor
		fix_t got_fix;
		fix_t want_fix;
		if (arst_n && m_tvalid && m_tready) begin
			got_fix.hour = m_tdata[6:0];
			got_fix.minute = m_tdata[13:7];
			got_fix.second = m_tdata[20:14];
			got_fix.lat = m_tdata[47:21];
			got_fix.lon = m_tdata[77:48];
			got_fix.south = m_tuser[0];
			got_fix.west = m_tuser[1];
			got_fix.fix = m_tuser[2];
			fixes_seen++;
			if (m_tdata[79:78] != 2'b00)
				flag_error("padding bits of the result are not zero");
			if (pending_fixes.size() == 0) begin
				flag_error("result transaction with no fix pending");
			end else begin
				want_fix = pending_fixes.pop_front();
				compare_fix(got_fix, want_fix);
			end
		end
		if (ready_left == 0) begin
			ready_mode = $urandom_range(0, 2);
			ready_left = $urandom_range(5, 60);
		end
		ready_left--;
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 2) != 0);
			default: m_tready <= ((ready_left % 7) >= 3);
		endcase
	end

	initial begin
		cfg_now.sync_char = 8'd36;
		cfg_now.delim_char = 8'd44;
		cfg_now.check_char = 8'd42;
		cfg_now.sentence_id = 40'd306255972161;
		parse_st = PH_IDLE;
		clear_sentence_state();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		test_random_traffic();
		wait_idle();
		if (pending_fixes.size() != 0)
			flag_error("fixes still pending at the end of the run");
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("ERROR: run timed out");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ nmea_gga_sentence_parser_unit.f @@
rtl/nggp_pkg.sv
rtl/nggp_parser.sv
rtl/nggp_convert.sv
rtl/nmea_gga_sentence_parser_unit.sv
tb/nmea_gga_sentence_parser_unit_test.sv
